// ===== rtl/dkwe_pkg.sv =====
// dkwe_pkg: shared types, constants and helper functions for the k-mer window encoder.
// Has no dependencies. Used by the interfaces, dkwe_step and dna_kmer_window_encoder.
package dkwe_pkg;

    // Longest sequence tracked; the base counter saturates below this
    localparam longint unsigned MAX_SEQ_LEN = 64'd65536;
    localparam logic [15:0] SEEN_CAP = (MAX_SEQ_LEN - 64'd1 > 64'd65535) ? 16'hFFFF
                                       : 16'(MAX_SEQ_LEN - 64'd1);

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_MER_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE  = 2'd1;

    localparam logic [5:0] MER_SIZE_RESET = 6'd20;
    localparam logic [5:0] K_MIN          = 6'd1;
    localparam logic [5:0] K_MAX          = 6'd32;

    // ASCII nucleotide letters
    localparam logic [7:0] CHAR_UA = 8'h41;
    localparam logic [7:0] CHAR_UC = 8'h43;
    localparam logic [7:0] CHAR_UG = 8'h47;
    localparam logic [7:0] CHAR_UT = 8'h54;
    localparam logic [7:0] CHAR_LA = 8'h61;
    localparam logic [7:0] CHAR_LC = 8'h63;
    localparam logic [7:0] CHAR_LG = 8'h67;
    localparam logic [7:0] CHAR_LT = 8'h74;

    // 2-bit base codes
    localparam logic [1:0] CODE_A = 2'd0;
    localparam logic [1:0] CODE_C = 2'd1;
    localparam logic [1:0] CODE_G = 2'd2;
    localparam logic [1:0] CODE_T = 2'd3;

    // Running state of the current sequence
    typedef struct packed {
        logic [63:0] window;
        logic [5:0]  until_valid;
        logic [15:0] seen;
        logic [15:0] usable;
    } state_t;

    // One result word
    typedef struct packed {
        logic [63:0] mer_value;
        logic        skip_flag;
        logic [15:0] mer_index;
        logic [15:0] usable_count;
    } result_t;

    // Clamp the programmed k into 1..32
    function automatic logic [5:0] eff_k(input logic [5:0] size);
        logic [5:0] k;
        k = size;
        if (k < K_MIN) k = K_MIN;
        if (k > K_MAX) k = K_MAX;
        return k;
    endfunction

    // Bit 2 set for an invalid symbol, bits 1:0 carry the base code
    function automatic logic [2:0] base_code(input logic [7:0] b);
        logic [2:0] r;
        unique case (b)
            CHAR_UA, CHAR_LA: r = {1'b0, CODE_A};
            CHAR_UC, CHAR_LC: r = {1'b0, CODE_C};
            CHAR_UG, CHAR_LG: r = {1'b0, CODE_G};
            CHAR_UT, CHAR_LT: r = {1'b0, CODE_T};
            default:          r = {1'b1, CODE_A};
        endcase
        return r;
    endfunction

    localparam logic [5:0] UNTIL_RESET = eff_k(MER_SIZE_RESET);

endpackage

// ===== rtl/dkwe_if.sv =====
// Handshake interfaces for the k-mer window encoder: base input, k-mer output, configuration.
// Depends on dkwe_pkg for the register index width.
interface dkwe_base_if;
    logic       valid;
    logic       ready;
    logic [7:0] base_byte;
    logic       first_base;

    modport source (output valid, base_byte, first_base, input ready);
    modport sink   (input valid, base_byte, first_base, output ready);
endinterface

interface dkwe_mer_if;
    logic        valid;
    logic        ready;
    logic [63:0] mer_value;
    logic        skip_flag;
    logic [15:0] mer_index;
    logic [15:0] usable_count;

    modport source (output valid, mer_value, skip_flag, mer_index, usable_count, input ready);
    modport sink   (input valid, mer_value, skip_flag, mer_index, usable_count, output ready);
endinterface

interface dkwe_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [dkwe_pkg::CFG_IDX_W-1:0] index;
    logic [5:0]                     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/dkwe_step.sv =====
// dkwe_step: next-state and result logic for one base of the k-mer window encoder.
// Purely combinational; depends on dkwe_pkg.
module dkwe_step (
    input  dkwe_pkg::state_t  cur,
    input  logic [5:0]        k,
    input  logic              rev,
    input  logic [7:0]        base_byte,
    input  logic              first_base,
    output dkwe_pkg::state_t  nxt,
    output logic              emit,
    output dkwe_pkg::result_t res
);

    dkwe_pkg::state_t st;
    logic [2:0]       sym;
    logic [63:0]      mask;
    logic [5:0]       until_clamped;
    logic [63:0]      win_next;
    logic [5:0]       until_next;
    logic [16:0]      pos;
    logic             skip;

    // Start of a sequence restarts everything
    always_comb
    begin
        if (first_base)
        begin
            st.window      = '0;
            st.until_valid = k;
            st.seen        = '0;
            st.usable      = '0;
        end
        else
        begin
            st = cur;
        end
        until_clamped = (st.until_valid > k) ? k : st.until_valid;
    end

    // Window mask: one bit pair per base below k
    always_comb
    begin
        for (int i = 0; i < 32; i++)
        begin
            mask[2*i +: 2] = (6'(i) < k) ? 2'b11 : 2'b00;
        end
    end

    // Shift in the base and update the countdown
    always_comb
    begin
        sym      = dkwe_pkg::base_code(base_byte);
        win_next = (st.window << 2) & mask;
        if (!sym[2])
        begin
            win_next[1:0] = sym[1:0] ^ {rev, rev};
            until_next    = (until_clamped != 6'd0) ? until_clamped - 6'd1 : 6'd0;
        end
        else
        begin
            until_next = k;
        end
    end

    // Position, emit decision and usable count
    always_comb
    begin
        nxt.window      = win_next;
        nxt.until_valid = until_next;
        nxt.seen        = (st.seen < dkwe_pkg::SEEN_CAP) ? st.seen + 16'd1 : st.seen;
        pos             = {1'b0, st.seen} + 17'd1;
        emit            = pos >= {11'd0, k};
        skip            = until_next != 6'd0;
        if (emit && !skip && st.usable < dkwe_pkg::COUNT_MAX)
            nxt.usable = st.usable + 16'd1;
        else
            nxt.usable = st.usable;

        res.mer_value    = win_next;
        res.skip_flag    = skip;
        res.mer_index    = 16'(pos - {11'd0, k});
        res.usable_count = nxt.usable;
    end

endmodule

// ===== rtl/dna_kmer_window_encoder.sv =====
// dna_kmer_window_encoder: top level of the rolling 2-bit k-mer encoder.
// Depends on dkwe_pkg, the interfaces in dkwe_if.sv and dkwe_step.
//
// One nucleotide byte goes in per word; each base is registered, encoded and shifted into the
// k-mer window by dkwe_step, and any result lands in an output register. A base is accepted
// every cycle while the output side keeps up, and its result passes from the input register
// through dkwe_step into the output register; the per-base state update in dkwe_step is the
// loop that sets this rate. Words that complete no k-mer yet produce no output.
// When the output stalls, one more base is held in the input register before ready drops.
// Configuration writes are always accepted and must only be issued while the block is idle;
// mer_size is clamped to 1..32.
module dna_kmer_window_encoder (
    input  logic             clk,
    input  logic             rst_n,
    dkwe_base_if.sink        bases,
    dkwe_mer_if.source       mers,
    dkwe_cfg_if.sink         cfg
);

    // Configuration registers
    logic [5:0] mer_size_reg;
    logic       reverse_reg;

    // Input stage
    logic       in_valid_reg;
    logic [7:0] base_reg;
    logic       first_reg;

    // Sequence state and result stage
    dkwe_pkg::state_t  state_reg;
    dkwe_pkg::state_t  state_next;
    dkwe_pkg::result_t res_next;
    dkwe_pkg::result_t res_reg;
    logic              out_valid_reg;
    logic              emit;
    logic              advance;
    logic [5:0]        k;

    assign k       = dkwe_pkg::eff_k(mer_size_reg);
    assign advance = in_valid_reg && (!out_valid_reg || mers.ready);

    assign bases.ready = !in_valid_reg || advance;
    assign cfg.ready   = 1'b1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mer_size_reg <= dkwe_pkg::MER_SIZE_RESET;
            reverse_reg  <= 1'b0;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == dkwe_pkg::REG_MER_SIZE)
                mer_size_reg <= cfg.data;
            else if (cfg.index == dkwe_pkg::REG_REVERSE)
                reverse_reg <= cfg.data[0];
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (bases.ready)
            in_valid_reg <= bases.valid;
    end

    always_ff @(posedge clk)
    begin
        if (bases.valid && bases.ready)
        begin
            base_reg  <= bases.base_byte;
            first_reg <= bases.first_base;
        end
    end

    dkwe_step u_step (
        .cur        (state_reg),
        .k          (k),
        .rev        (reverse_reg),
        .base_byte  (base_reg),
        .first_base (first_reg),
        .nxt        (state_next),
        .emit       (emit),
        .res        (res_next)
    );

    // Sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.window      <= '0;
            state_reg.until_valid <= dkwe_pkg::UNTIL_RESET;
            state_reg.seen        <= '0;
            state_reg.usable      <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= emit;
        else if (mers.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
            res_reg <= res_next;
    end

    assign mers.valid        = out_valid_reg;
    assign mers.mer_value    = res_reg.mer_value;
    assign mers.skip_flag    = res_reg.skip_flag;
    assign mers.mer_index    = res_reg.mer_index;
    assign mers.usable_count = res_reg.usable_count;

    // Ready only drops with both stages full and the output stalled
    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        !bases.ready |-> in_valid_reg && out_valid_reg && !mers.ready)
        else $error("input stalled without a full pipeline");

    // A fresh result carries the updated usable total
    a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
        advance && emit |=> out_valid_reg && res_reg.usable_count == state_reg.usable)
        else $error("result count disagrees with state");

    // Usable total only falls when a new sequence starts
    a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !first_reg |=> state_reg.usable >= $past(state_reg.usable))
        else $error("usable count went backwards");

endmodule

// ===== dv/tb_dna_kmer_window_encoder.sv =====
// tb_dna_kmer_window_encoder: self-checking testbench for the rolling 2-bit k-mer encoder.
// Depends on dkwe_pkg, the handshake interfaces in dkwe_if.sv and dna_kmer_window_encoder.
// Base words are predicted on acceptance; each k-mer word is checked against the oldest one.
module tb_dna_kmer_window_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    // Index with no register behind it; writes to it must change nothing
    localparam logic [dkwe_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam int DRAIN_CYCLES   = 8;
    localparam int STALL_LIMIT    = 4000;

    logic clk;
    logic rst_n;

    dkwe_base_if bases ();
    dkwe_mer_if  mers ();
    dkwe_cfg_if  cfg ();

    dna_kmer_window_encoder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .bases (bases.sink),
        .mers  (mers.source),
        .cfg   (cfg.sink)
    );

    // Programmed registers as the block should see them
    logic [5:0]  k_setting;
    logic        rev_setting;

    // Predicted sequence state
    logic [63:0] win_bits;
    int          countdown;
    logic [15:0] seen_bases;
    logic [15:0] usable_mers;

    dkwe_pkg::result_t pending_mers[$];
    int                mismatches;
    int                tx_idle_pct;
    int                rx_idle_pct;
    int                stall_cycles;

    always #2 clk = ~clk;

    // k as the block applies it: 0 acts as 1, anything above 32 as 32
    function automatic int k_of(input logic [5:0] size);
        if (size == 6'd0)
            return 1;
        if (size > 6'd32)
            return 32;
        return int'(size);
    endfunction

    function automatic logic [7:0] random_letter();
        case ($urandom_range(7))
            0: return dkwe_pkg::CHAR_UA;
            1: return dkwe_pkg::CHAR_UC;
            2: return dkwe_pkg::CHAR_UG;
            3: return dkwe_pkg::CHAR_UT;
            4: return dkwe_pkg::CHAR_LA;
            5: return dkwe_pkg::CHAR_LC;
            6: return dkwe_pkg::CHAR_LG;
            default: return dkwe_pkg::CHAR_LT;
        endcase
    endfunction

    // Advance the predicted state by one base; returns 1 when a k-mer word is due
    function automatic bit predict_mer(input logic [7:0] b, input logic first,
                                       output dkwe_pkg::result_t r);
        int          k;
        logic [1:0]  sym;
        bit          is_base;
        logic [15:0] idx;
        bit          skip;

        k = k_of(k_setting);
        r = '0;
        if (first)
        begin
            win_bits    = '0;
            countdown   = k;
            seen_bases  = '0;
            usable_mers = '0;
        end
        if (countdown > k)
            countdown = k;

        is_base = 1'b1;
        sym     = dkwe_pkg::CODE_A;
        case (b)
            dkwe_pkg::CHAR_UA, dkwe_pkg::CHAR_LA: sym = dkwe_pkg::CODE_A;
            dkwe_pkg::CHAR_UC, dkwe_pkg::CHAR_LC: sym = dkwe_pkg::CODE_C;
            dkwe_pkg::CHAR_UG, dkwe_pkg::CHAR_LG: sym = dkwe_pkg::CODE_G;
            dkwe_pkg::CHAR_UT, dkwe_pkg::CHAR_LT: sym = dkwe_pkg::CODE_T;
            default:                              is_base = 1'b0;
        endcase

        win_bits = win_bits << 2;
        if (k < 32)
            win_bits = win_bits & ((64'd1 << (2 * k)) - 64'd1);
        if (is_base)
        begin
            if (rev_setting)
                sym = sym ^ 2'b11;
            win_bits[1:0] = sym;
            if (countdown > 0)
                countdown--;
        end
        else
            countdown = k;

        idx = seen_bases;
        if (seen_bases < dkwe_pkg::SEEN_CAP)
            seen_bases++;
        if (int'(idx) + 1 < k)
            return 1'b0;

        skip = (countdown > 0);
        if (!skip && usable_mers < dkwe_pkg::COUNT_MAX)
            usable_mers++;
        r.mer_value    = win_bits;
        r.skip_flag    = skip;
        r.mer_index    = 16'(int'(idx) + 1 - k);
        r.usable_count = usable_mers;
        return 1'b1;
    endfunction

    // Send one base word, with random idle cycles ahead of it
    task automatic send_base(input logic [7:0] b, input logic first);
        dkwe_pkg::result_t r;

        while ($urandom_range(99) < tx_idle_pct)
        begin
            @(negedge clk);
            bases.valid <= 1'b0;
        end
        @(negedge clk);
        bases.valid      <= 1'b1;
        bases.base_byte  <= b;
        bases.first_base <= first;
        do
            @(posedge clk);
        while (!bases.ready);
        if (predict_mer(b, first, r))
            pending_mers.push_back(r);
    endtask

    // Drop valid, let every expected word arrive and the pipeline empty
    task automatic wait_drained();
        @(negedge clk);
        bases.valid <= 1'b0;
        while (pending_mers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [dkwe_pkg::CFG_IDX_W-1:0] idx, input logic [5:0] val);
        wait_drained();
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do
            @(posedge clk);
        while (!cfg.ready);
        if (idx == dkwe_pkg::REG_MER_SIZE)
            k_setting = val;
        else if (idx == dkwe_pkg::REG_REVERSE)
            rev_setting = val[0];
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // Bases straight after reset with the reset k of 20 and no start-of-sequence mark
    task automatic test_reset_state();
        for (int i = 0; i < 21; i++)
            send_base(random_letter(), 1'b0);
    endtask

    // Every letter in both cases, invalid symbols, recovery and a restart, then the reverse strand
    task automatic test_directed();
        write_reg(dkwe_pkg::REG_MER_SIZE, 6'd2);
        write_reg(REG_SPARE, 6'h3F);
        send_base(dkwe_pkg::CHAR_UA, 1'b1);
        send_base(dkwe_pkg::CHAR_LC, 1'b0);
        send_base(dkwe_pkg::CHAR_UG, 1'b0);
        send_base(dkwe_pkg::CHAR_LT, 1'b0);
        send_base(dkwe_pkg::CHAR_LA, 1'b0);
        send_base(dkwe_pkg::CHAR_UC, 1'b0);
        send_base(dkwe_pkg::CHAR_LG, 1'b0);
        send_base(dkwe_pkg::CHAR_UT, 1'b0);
        send_base("N", 1'b0);
        send_base(8'h00, 1'b0);
        send_base(8'hFF, 1'b0);
        send_base(dkwe_pkg::CHAR_UA, 1'b0);
        send_base(dkwe_pkg::CHAR_UC, 1'b0);
        send_base(dkwe_pkg::CHAR_UG, 1'b1);
        send_base(dkwe_pkg::CHAR_UT, 1'b0);
        write_reg(dkwe_pkg::REG_MER_SIZE, 6'd1);
        write_reg(dkwe_pkg::REG_REVERSE, 6'd1);
        send_base(dkwe_pkg::CHAR_UA, 1'b1);
        send_base(dkwe_pkg::CHAR_UC, 1'b0);
        send_base(dkwe_pkg::CHAR_UG, 1'b0);
        send_base(dkwe_pkg::CHAR_UT, 1'b0);
        send_base("x", 1'b0);
    endtask

    // Random sequences over several register settings, extremes of k among them
    task automatic test_random(input int n_items);
        int         per_phase;
        int         left;
        int         k;
        int         pick;
        logic [5:0] size;
        logic [7:0] b;
        logic       first;

        per_phase = n_items / 5;
        left      = 0;
        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0:       size = 6'd1;
                1:       size = 6'd32;
                2:       size = 6'd0;
                3:       size = 6'd63;
                default: size = 6'($urandom_range(2, 31));
            endcase
            // no restart here: k changes under a running sequence
            write_reg(dkwe_pkg::REG_MER_SIZE, size);
            write_reg(dkwe_pkg::REG_REVERSE, 6'($urandom_range(63)));
            k = k_of(size);
            for (int i = 0; i < per_phase; i++)
            begin
                if (left == 0)
                begin
                    left  = $urandom_range(1, 3 * k + 6);
                    first = ($urandom_range(9) != 0);
                end
                else
                    first = 1'b0;
                if ($urandom_range(19) == 0)
                    first = 1'($urandom_range(1));
                pick = $urandom_range(99);
                if (pick < 88)
                    b = random_letter();
                else
                    b = 8'($urandom_range(255));
                send_base(b, first);
                left--;
            end
        end
    endtask

    // Receiver back-pressure
    always @(negedge clk)
        mers.ready <= ($urandom_range(99) >= rx_idle_pct);

    // Check each k-mer word against the oldest prediction
    always @(posedge clk)
    begin
        dkwe_pkg::result_t e;

        if (rst_n && mers.valid && mers.ready)
        begin
            if (pending_mers.size() == 0)
            begin
                mismatches++;
                $error("unexpected k-mer word: mer_index %0d", mers.mer_index);
            end
            else
            begin
                e = pending_mers.pop_front();
                if (mers.mer_value !== e.mer_value)
                begin
                    mismatches++;
                    $error("mer_value: expected %h, got %h", e.mer_value, mers.mer_value);
                end
                if (mers.skip_flag !== e.skip_flag)
                begin
                    mismatches++;
                    $error("skip_flag: expected %0d, got %0d", e.skip_flag, mers.skip_flag);
                end
                if (mers.mer_index !== e.mer_index)
                begin
                    mismatches++;
                    $error("mer_index: expected %0d, got %0d", e.mer_index, mers.mer_index);
                end
                if (mers.usable_count !== e.usable_count)
                begin
                    mismatches++;
                    $error("usable_count: expected %0d, got %0d",
                           e.usable_count, mers.usable_count);
                end
            end
        end
    end

    // Watchdog: too long with no word moving on any channel
    always @(posedge clk)
    begin
        if ((bases.valid && bases.ready) || (mers.valid && mers.ready)
            || (cfg.valid && cfg.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("** dna_kmer_window_encoder: FAILED **");
            $finish;
        end
    end

    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        bases.valid      = 1'b0;
        bases.base_byte  = '0;
        bases.first_base = 1'b0;
        mers.ready       = 1'b0;
        cfg.valid        = 1'b0;
        cfg.index        = '0;
        cfg.data         = '0;
        stall_cycles     = 0;
        mismatches       = 0;

        // predictor in its reset state
        k_setting   = dkwe_pkg::MER_SIZE_RESET;
        rev_setting = 1'b0;
        win_bits    = '0;
        countdown   = k_of(dkwe_pkg::MER_SIZE_RESET);
        seen_bases  = '0;
        usable_mers = '0;

        tx_idle_pct = 31;
        rx_idle_pct = 86;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_directed();
        test_random(470);
        tx_idle_pct = 86;
        rx_idle_pct = 31;
        test_random(470);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random(470);

        wait_drained();
        if (mismatches == 0)
            $display("** dna_kmer_window_encoder: PASSED **");
        else
            $display("** dna_kmer_window_encoder: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/dkwe_pkg.sv
rtl/dkwe_if.sv
rtl/dkwe_step.sv
rtl/dna_kmer_window_encoder.sv
dv/tb_dna_kmer_window_encoder.sv
